// ===== hw/rtl/ccbrm_pkg.sv =====
// ccbrm_pkg: shared types and constants for the console CPU bus register map.
// No dependencies.
package ccbrm_pkg;

   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_VBLANK = 2'd2;

   localparam logic [15:0] ADDR_CTRL     = 16'h2000;
   localparam logic [15:0] ADDR_MASK     = 16'h2001;
   localparam logic [15:0] ADDR_STATUS   = 16'h2002;
   localparam logic [15:0] ADDR_SPR_ADDR = 16'h2003;
   localparam logic [15:0] ADDR_SPR_DATA = 16'h2004;
   localparam logic [15:0] ADDR_SCROLL   = 16'h2005;
   localparam logic [15:0] ADDR_VADDR    = 16'h2006;
   localparam logic [15:0] ADDR_VDATA    = 16'h2007;
   localparam logic [15:0] ADDR_DMA      = 16'h4014;
   localparam logic [15:0] ADDR_PAD      = 16'h4016;
   localparam logic [15:0] WORK_RAM_LIMIT = 16'h0800;

   localparam logic [15:0] PALETTE_BASE    = 16'h3F00;
   localparam logic [15:0] PAL_MIRROR_0    = 16'h3F10;
   localparam logic [15:0] PAL_MIRROR_1    = 16'h3F14;
   localparam logic [15:0] PAL_MIRROR_2    = 16'h3F18;
   localparam logic [15:0] PAL_MIRROR_3    = 16'h3F1C;
   localparam logic [15:0] PAL_MIRROR_MASK = 16'hFFEF;
   localparam logic [15:0] STEP_ROW        = 16'd32;
   localparam logic [15:0] STEP_COL        = 16'd1;

   localparam int WORK_INDEX_W  = 11;   // address span below the work RAM limit
   localparam int VIDEO_INDEX_W = 13;   // video address bits 12..0
   localparam int VIDEO_SEL_BIT = 13;   // 1: video RAM, 0: pattern RAM

   localparam logic [3:0] PAD_BITS = 4'd8;

   typedef enum logic [1:0] {
      SRC_IMM,
      SRC_WORK,
      SRC_VIDEO,
      SRC_PATTERN
   } src_type;

   typedef struct packed {
      src_type    src;
      logic       use_buffer;
      logic [7:0] imm_data;
      logic       nmi_enable;
      logic [1:0] pattern_select;
      logic [1:0] nametable_select;
      logic [3:0] render_controls;
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic       dma_request;
      logic [7:0] dma_page;
      logic       vblank_flag;
   } stage_type;

   typedef struct packed {
      logic [7:0] work;
      logic [7:0] video;
      logic [7:0] pattern;
   } mem_data_type;

endpackage

// ===== hw/rtl/ccbrm_ram.sv =====
// ccbrm_ram: single-port RAM, one access per clock, registered read data.
// No dependencies.
module ccbrm_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ccbrm_decode.sv =====
// ccbrm_decode: register decode, register state, memories and the stage
// register after decode. Depends on ccbrm_pkg and ccbrm_ram.
module ccbrm_decode #(
   parameter int WORK_RAM_DEPTH   = 2048,
   parameter int VIDEO_RAM_DEPTH  = 8192,
   parameter int PATTERN_DEPTH    = 8192,
   parameter int SPRITE_RAM_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    advance,
   input  logic [1:0]              func,
   input  logic [15:0]             bus_addr,
   input  logic [7:0]              write_data,
   input  logic [7:0]              pad_buttons,
   input  logic                    sprite_hit,
   input  logic                    sprite_overflow,
   output logic                    stage_valid,
   output ccbrm_pkg::stage_type    stage,
   output ccbrm_pkg::mem_data_type mem_data
);
   import ccbrm_pkg::*;

   localparam int WORK_AW    = $clog2(WORK_RAM_DEPTH);
   localparam int VIDEO_AW   = $clog2(VIDEO_RAM_DEPTH);
   localparam int PATTERN_AW = $clog2(PATTERN_DEPTH);
   localparam int SPRITE_AW  = $clog2(SPRITE_RAM_DEPTH);
   localparam int WORK_SPAN  = 2 ** WORK_INDEX_W;
   localparam int VIDEO_SPAN = 2 ** VIDEO_INDEX_W;
   localparam int WORK_STEPS    = $clog2((WORK_SPAN + WORK_RAM_DEPTH - 1) / WORK_RAM_DEPTH);
   localparam int VIDEO_STEPS   = $clog2((VIDEO_SPAN + VIDEO_RAM_DEPTH - 1) / VIDEO_RAM_DEPTH);
   localparam int PATTERN_STEPS = $clog2((VIDEO_SPAN + PATTERN_DEPTH - 1) / PATTERN_DEPTH);

   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  sprite_addr_ff, sprite_addr_in;
   logic [15:0] video_addr_ff, video_addr_in;
   logic        scroll_toggle_ff, scroll_toggle_in;
   logic        addr_toggle_ff, addr_toggle_in;
   logic        vblank_ff, vblank_in;
   logic        strobe_armed_ff, strobe_armed_in;
   logic [3:0]  pad_index_ff, pad_index_in;
   logic [7:0]  pad_latch_ff, pad_latch_in;
   logic [7:0]  scroll_x_ff, scroll_x_in;
   logic [7:0]  scroll_y_ff, scroll_y_in;
   logic [7:0]  dma_page_ff, dma_page_in;
   logic        stage_valid_ff, stage_valid_in;
   stage_type   stage_ff, stage_in;

   logic [15:0] mirrored;
   logic [15:0] video_step;
   logic [VIDEO_INDEX_W-1:0] video_idx, pattern_idx;
   logic [WORK_INDEX_W-1:0]  work_idx;
   logic is_read, is_write, vdata_hit, work_hit, video_sel;

   // Palette mirror and address steps
   always_comb begin
      mirrored = video_addr_ff;
      if (video_addr_ff == PAL_MIRROR_0 || video_addr_ff == PAL_MIRROR_1 ||
          video_addr_ff == PAL_MIRROR_2 || video_addr_ff == PAL_MIRROR_3) begin
         mirrored = video_addr_ff & PAL_MIRROR_MASK;
      end
      video_step = ctrl_ff[2] ? STEP_ROW : STEP_COL;
   end

   // Index reduction modulo each depth
   always_comb begin
      video_idx   = mirrored[VIDEO_INDEX_W-1:0];
      pattern_idx = mirrored[VIDEO_INDEX_W-1:0];
      work_idx    = bus_addr[WORK_INDEX_W-1:0];
      for (int k = VIDEO_STEPS - 1; k >= 0; k--) begin
         if (int'(video_idx) >= (VIDEO_RAM_DEPTH << k)) begin
            video_idx = video_idx - VIDEO_INDEX_W'(VIDEO_RAM_DEPTH << k);
         end
      end
      for (int k = PATTERN_STEPS - 1; k >= 0; k--) begin
         if (int'(pattern_idx) >= (PATTERN_DEPTH << k)) begin
            pattern_idx = pattern_idx - VIDEO_INDEX_W'(PATTERN_DEPTH << k);
         end
      end
      for (int k = WORK_STEPS - 1; k >= 0; k--) begin
         if (int'(work_idx) >= (WORK_RAM_DEPTH << k)) begin
            work_idx = work_idx - WORK_INDEX_W'(WORK_RAM_DEPTH << k);
         end
      end
   end

   assign is_read   = accept && (func == FUNC_READ);
   assign is_write  = accept && (func == FUNC_WRITE);
   assign vdata_hit = (bus_addr == ADDR_VDATA);
   assign work_hit  = (bus_addr < WORK_RAM_LIMIT);
   assign video_sel = mirrored[VIDEO_SEL_BIT];

   always_comb begin
      ctrl_in          = ctrl_ff;
      mask_in          = mask_ff;
      sprite_addr_in   = sprite_addr_ff;
      video_addr_in    = video_addr_ff;
      scroll_toggle_in = scroll_toggle_ff;
      addr_toggle_in   = addr_toggle_ff;
      vblank_in        = vblank_ff;
      strobe_armed_in  = strobe_armed_ff;
      pad_index_in     = pad_index_ff;
      pad_latch_in     = pad_latch_ff;
      scroll_x_in      = scroll_x_ff;
      scroll_y_in      = scroll_y_ff;
      dma_page_in      = dma_page_ff;
      stage_in         = stage_ff;
      stage_in.src         = SRC_IMM;
      stage_in.use_buffer  = 1'b0;
      stage_in.imm_data    = 8'd0;
      stage_in.dma_request = 1'b0;
      if (accept) begin
         case (func)
            FUNC_READ: begin
               if (bus_addr == ADDR_STATUS) begin
                  stage_in.imm_data = {vblank_ff, sprite_hit, sprite_overflow, 5'd0};
                  vblank_in        = 1'b0;
                  scroll_toggle_in = 1'b0;
                  addr_toggle_in   = 1'b0;
               end else if (vdata_hit) begin
                  stage_in.src        = video_sel ? SRC_VIDEO : SRC_PATTERN;
                  stage_in.use_buffer = (mirrored < PALETTE_BASE);
                  video_addr_in       = video_addr_ff + video_step;
               end else if (bus_addr == ADDR_PAD) begin
                  if (pad_index_ff < PAD_BITS) begin
                     stage_in.imm_data = {7'd0, pad_latch_ff[pad_index_ff[2:0]]};
                     pad_index_in      = pad_index_ff + 4'd1;
                  end
               end else if (work_hit) begin
                  stage_in.src = SRC_WORK;
               end
            end
            FUNC_WRITE: begin
               case (bus_addr)
                  ADDR_CTRL:     ctrl_in = write_data;
                  ADDR_MASK:     mask_in = write_data;
                  ADDR_SPR_ADDR: sprite_addr_in = write_data;
                  ADDR_SPR_DATA: sprite_addr_in = sprite_addr_ff + 8'd1;
                  ADDR_SCROLL: begin
                     if (!scroll_toggle_ff) begin
                        scroll_x_in = write_data;
                     end else begin
                        scroll_y_in = write_data;
                     end
                     scroll_toggle_in = !scroll_toggle_ff;
                  end
                  ADDR_VADDR: begin
                     if (!addr_toggle_ff) begin
                        video_addr_in = {write_data, video_addr_ff[7:0]};
                     end else begin
                        video_addr_in = {video_addr_ff[15:8], write_data};
                     end
                     addr_toggle_in = !addr_toggle_ff;
                  end
                  ADDR_VDATA:    video_addr_in = video_addr_ff + video_step;
                  ADDR_DMA: begin
                     dma_page_in          = write_data;
                     stage_in.dma_request = 1'b1;
                  end
                  ADDR_PAD: begin
                     if (!strobe_armed_ff && write_data[0]) begin
                        strobe_armed_in = 1'b1;
                     end else if (strobe_armed_ff && !write_data[0]) begin
                        strobe_armed_in = 1'b0;
                        pad_index_in    = 4'd0;
                        pad_latch_in    = pad_buttons;
                     end
                  end
                  default: ;
               endcase
            end
            FUNC_VBLANK: vblank_in = 1'b1;
            default: ;
         endcase
      end
      stage_in.nmi_enable       = ctrl_in[7];
      stage_in.pattern_select   = {ctrl_in[4], ctrl_in[3]};
      stage_in.nametable_select = ctrl_in[1:0];
      stage_in.render_controls  = mask_in[4:1];
      stage_in.scroll_x         = scroll_x_in;
      stage_in.scroll_y         = scroll_y_in;
      stage_in.dma_page         = dma_page_in;
      stage_in.vblank_flag      = vblank_in;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff          <= '0;
         mask_ff          <= '0;
         sprite_addr_ff   <= '0;
         video_addr_ff    <= '0;
         scroll_toggle_ff <= 1'b0;
         addr_toggle_ff   <= 1'b0;
         vblank_ff        <= 1'b0;
         strobe_armed_ff  <= 1'b0;
         pad_index_ff     <= '0;
         pad_latch_ff     <= '0;
         scroll_x_ff      <= '0;
         scroll_y_ff      <= '0;
         dma_page_ff      <= '0;
         stage_valid_ff   <= 1'b0;
      end else begin
         ctrl_ff          <= ctrl_in;
         mask_ff          <= mask_in;
         sprite_addr_ff   <= sprite_addr_in;
         video_addr_ff    <= video_addr_in;
         scroll_toggle_ff <= scroll_toggle_in;
         addr_toggle_ff   <= addr_toggle_in;
         vblank_ff        <= vblank_in;
         strobe_armed_ff  <= strobe_armed_in;
         pad_index_ff     <= pad_index_in;
         pad_latch_ff     <= pad_latch_in;
         scroll_x_ff      <= scroll_x_in;
         scroll_y_ff      <= scroll_y_in;
         dma_page_ff      <= dma_page_in;
         stage_valid_ff   <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   ccbrm_ram #(.DEPTH(WORK_RAM_DEPTH), .WIDTH(8)) u_work_ram (
      .clock   (clock),
      .wr_en   (is_write && work_hit),
      .rd_en   (is_read && work_hit),
      .addr    (work_idx[WORK_AW-1:0]),
      .wr_data (write_data),
      .rd_data (mem_data.work)
   );

   ccbrm_ram #(.DEPTH(VIDEO_RAM_DEPTH), .WIDTH(8)) u_video_ram (
      .clock   (clock),
      .wr_en   (is_write && vdata_hit && video_sel),
      .rd_en   (is_read && vdata_hit && video_sel),
      .addr    (video_idx[VIDEO_AW-1:0]),
      .wr_data (write_data),
      .rd_data (mem_data.video)
   );

   ccbrm_ram #(.DEPTH(PATTERN_DEPTH), .WIDTH(8)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (is_write && vdata_hit && !video_sel),
      .rd_en   (is_read && vdata_hit && !video_sel),
      .addr    (pattern_idx[PATTERN_AW-1:0]),
      .wr_data (write_data),
      .rd_data (mem_data.pattern)
   );

   // Sprite memory is write-only from the CPU side
   ccbrm_ram #(.DEPTH(SPRITE_RAM_DEPTH), .WIDTH(8)) u_sprite_ram (
      .clock   (clock),
      .wr_en   (is_write && (bus_addr == ADDR_SPR_DATA)),
      .rd_en   (1'b0),
      .addr    (sprite_addr_ff[SPRITE_AW-1:0]),
      .wr_data (write_data),
      .rd_data ()
   );

endmodule

// ===== hw/rtl/console_cpu_bus_register_map.sv =====
// console_cpu_bus_register_map_core: top level, output stage and read buffer.
// Depends on ccbrm_pkg and ccbrm_decode.
//
// Usage:
//   req_* carries one CPU bus access (func 0 read, 1 write) or a vertical
//   blank event (func 2). Every request gives exactly one rsp_* result: the
//   read byte (0 for writes and events) and a snapshot of the control, mask,
//   scroll, DMA and vblank state after that request.
//   Pipeline: decode state and memory read data register at the accepting edge;
//   the output register, which drives rsp_valid, loads when the result advances.
//   Throughput: one request per cycle while rsp_ready is high, set by the
//   single-port memories that take one access per clock.
//   rsp_dma_request is high only in the result of a write to the DMA register.
//   Reset clears all register state; memory contents stay undefined until
//   written and need no clearing pass.
//   When rsp_ready is low, one result waits in the output register and one
//   more in the decode stage; req_ready drops only when both are full.
module console_cpu_bus_register_map_core #(
   parameter int WORK_RAM_DEPTH   = 2048,
   parameter int VIDEO_RAM_DEPTH  = 8192,
   parameter int PATTERN_DEPTH    = 8192,
   parameter int SPRITE_RAM_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_bus_addr,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_pad_buttons,
   input  logic        req_sprite_hit,
   input  logic        req_sprite_overflow,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_enable,
   output logic [1:0]  rsp_pattern_select,
   output logic [1:0]  rsp_nametable_select,
   output logic [3:0]  rsp_render_controls,
   output logic [7:0]  rsp_scroll_x,
   output logic [7:0]  rsp_scroll_y,
   output logic        rsp_dma_request,
   output logic [7:0]  rsp_dma_page,
   output logic        rsp_vblank_flag
);
   import ccbrm_pkg::*;

   logic         accept, advance, stage_valid;
   stage_type    stage;
   mem_data_type mem_data;
   logic [7:0]   mem_value, data_in, read_buffer_in;
   logic [7:0]   read_buffer_ff, read_data_ff;
   stage_type    out_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign advance   = stage_valid && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid || advance;
   assign accept    = req_valid && req_ready;

   ccbrm_decode #(
      .WORK_RAM_DEPTH   (WORK_RAM_DEPTH),
      .VIDEO_RAM_DEPTH  (VIDEO_RAM_DEPTH),
      .PATTERN_DEPTH    (PATTERN_DEPTH),
      .SPRITE_RAM_DEPTH (SPRITE_RAM_DEPTH)
   ) u_decode (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .advance         (advance),
      .func            (req_func),
      .bus_addr        (req_bus_addr),
      .write_data      (req_write_data),
      .pad_buttons     (req_pad_buttons),
      .sprite_hit      (req_sprite_hit),
      .sprite_overflow (req_sprite_overflow),
      .stage_valid     (stage_valid),
      .stage           (stage),
      .mem_data        (mem_data)
   );

   always_comb begin
      case (stage.src)
         SRC_WORK:    mem_value = mem_data.work;
         SRC_VIDEO:   mem_value = mem_data.video;
         SRC_PATTERN: mem_value = mem_data.pattern;
         default:     mem_value = stage.imm_data;
      endcase
      data_in        = mem_value;
      read_buffer_in = read_buffer_ff;
      if ((stage.src == SRC_VIDEO || stage.src == SRC_PATTERN) && stage.use_buffer) begin
         data_in        = read_buffer_ff;
         read_buffer_in = mem_value;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         read_buffer_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            read_buffer_ff <= read_buffer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff       <= stage;
         read_data_ff <= data_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = read_data_ff;
   assign rsp_nmi_enable       = out_ff.nmi_enable;
   assign rsp_pattern_select   = out_ff.pattern_select;
   assign rsp_nametable_select = out_ff.nametable_select;
   assign rsp_render_controls  = out_ff.render_controls;
   assign rsp_scroll_x         = out_ff.scroll_x;
   assign rsp_scroll_y         = out_ff.scroll_y;
   assign rsp_dma_request      = out_ff.dma_request;
   assign rsp_dma_page         = out_ff.dma_page;
   assign rsp_vblank_flag      = out_ff.vblank_flag;

endmodule

// ===== hw/rtl/ccbrm_checker.sv =====
// ccbrm_checker: port-level assertions for console_cpu_bus_register_map_core,
// attached by bind. Depends on the top level's port list only.
module ccbrm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_dma_request,
   input logic [7:0] rsp_dma_page,
   input logic       rsp_vblank_flag
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its data
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result changed");

   // DMA page only changes in a result that carries a DMA request
   a_dma_page: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && $past(rsp_fire) && !$past(reset) && !rsp_dma_request
      |-> rsp_dma_page == $past(rsp_dma_page))
      else $error("DMA page changed without request");

   // vblank only rises on an event, whose read data is zero
   a_vblank_rise: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && $past(rsp_fire) && !$past(reset) && rsp_vblank_flag
      && !$past(rsp_vblank_flag) |-> rsp_read_data == 8'd0)
      else $error("vblank rose on a read result");

endmodule

bind console_cpu_bus_register_map_core ccbrm_checker u_ccbrm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_data   (rsp_read_data),
   .rsp_dma_request (rsp_dma_request),
   .rsp_dma_page    (rsp_dma_page),
   .rsp_vblank_flag (rsp_vblank_flag)
);

// ===== test/console_cpu_bus_register_map_core_tb.sv =====
// Self-checking testbench for console_cpu_bus_register_map_core: CPU bus accesses and
// vblank events in, one register snapshot out per request, checked against an in-bench
// scoreboard. Depends on ccbrm_pkg and the core RTL.
`timescale 1ns / 1ps

module console_cpu_bus_register_map_core_tb;
   import ccbrm_pkg::*;

   localparam logic [1:0] FUNC_IDLE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1050;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  buttons;
      logic        hit;
      logic        ovf;
   } bus_req_t;

   typedef struct packed {
      logic [7:0] rdata;
      logic       nmi;
      logic [1:0] pattern;
      logic [1:0] nametable;
      logic [3:0] render;
      logic [7:0] sx;
      logic [7:0] sy;
      logic       dma_req;
      logic [7:0] dma_page;
      logic       vblank;
   } bus_rsp_t;

   class regmap_scoreboard;
      bit [7:0]  work_mem[2048];
      bit        work_ok[2048];
      bit [7:0]  video_mem[8192];
      bit [7:0]  pattern_mem[8192];
      bit        video_ok[8192];
      bit        pattern_ok[8192];
      bit [15:0] vaddr;
      bit        row_step, scroll_toggle, addr_toggle, vblank, strobe_armed;
      bit [3:0]  pad_index;
      bit [7:0]  read_buf, pad_latch, ctrl_reg, mask_reg, scroll_x, scroll_y, dma_page;
      bus_rsp_t  pending_rsp[$];
      int        errors;

      function bit [15:0] mirror(bit [15:0] a);
         if (a == PAL_MIRROR_0 || a == PAL_MIRROR_1 || a == PAL_MIRROR_2 || a == PAL_MIRROR_3)
            return a & PAL_MIRROR_MASK;
         return a;
      endfunction

      function bit cell_written(bit [15:0] a);
         return a[VIDEO_SEL_BIT] ? video_ok[a[VIDEO_INDEX_W-1:0]]
                                 : pattern_ok[a[VIDEO_INDEX_W-1:0]];
      endfunction

      function void predict_access(bus_req_t r);
         bus_rsp_t  e;
         bit [15:0] a;
         bit [12:0] idx;
         bit [7:0]  v;
         e = '0;
         a = mirror(vaddr);
         idx = a[VIDEO_INDEX_W-1:0];
         case (r.func)
            FUNC_READ: begin
               if (r.addr == ADDR_STATUS) begin
                  e.rdata = {vblank, r.hit, r.ovf, 5'b0};
                  vblank = 0;
                  scroll_toggle = 0;
                  addr_toggle = 0;
               end else if (r.addr == ADDR_VDATA) begin
                  v = a[VIDEO_SEL_BIT] ? video_mem[idx] : pattern_mem[idx];
                  if (a < PALETTE_BASE) begin
                     e.rdata = read_buf;
                     read_buf = v;
                  end else begin
                     e.rdata = v;
                  end
                  vaddr = vaddr + (row_step ? STEP_ROW : STEP_COL);
               end else if (r.addr == ADDR_PAD) begin
                  if (pad_index < PAD_BITS) begin
                     e.rdata = {7'b0, pad_latch[pad_index[2:0]]};
                     pad_index++;
                  end
               end else if (r.addr < WORK_RAM_LIMIT) begin
                  e.rdata = work_mem[r.addr[WORK_INDEX_W-1:0]];
               end
            end
            FUNC_WRITE: begin
               case (r.addr)
                  ADDR_CTRL: begin
                     ctrl_reg = r.wdata;
                     row_step = r.wdata[2];
                  end
                  ADDR_MASK: mask_reg = r.wdata;
                  ADDR_SPR_ADDR, ADDR_SPR_DATA: ;  // sprite memory never shows in a result
                  ADDR_SCROLL: begin
                     if (!scroll_toggle) scroll_x = r.wdata;
                     else scroll_y = r.wdata;
                     scroll_toggle = !scroll_toggle;
                  end
                  ADDR_VADDR: begin
                     if (!addr_toggle) vaddr[15:8] = r.wdata;
                     else vaddr[7:0] = r.wdata;
                     addr_toggle = !addr_toggle;
                  end
                  ADDR_VDATA: begin
                     if (a[VIDEO_SEL_BIT]) begin
                        video_mem[idx] = r.wdata;
                        video_ok[idx] = 1;
                     end else begin
                        pattern_mem[idx] = r.wdata;
                        pattern_ok[idx] = 1;
                     end
                     vaddr = vaddr + (row_step ? STEP_ROW : STEP_COL);
                  end
                  ADDR_DMA: begin
                     dma_page = r.wdata;
                     e.dma_req = 1;
                  end
                  ADDR_PAD: begin
                     if (strobe_armed && !r.wdata[0]) begin
                        strobe_armed = 0;
                        pad_index = 0;
                        pad_latch = r.buttons;
                     end else if (!strobe_armed && r.wdata[0]) begin
                        strobe_armed = 1;
                     end
                  end
                  default: begin
                     if (r.addr < WORK_RAM_LIMIT) begin
                        work_mem[r.addr[WORK_INDEX_W-1:0]] = r.wdata;
                        work_ok[r.addr[WORK_INDEX_W-1:0]] = 1;
                     end
                  end
               endcase
            end
            FUNC_VBLANK: vblank = 1;
            default: ;
         endcase
         e.nmi = ctrl_reg[7];
         e.pattern = {ctrl_reg[4], ctrl_reg[3]};
         e.nametable = ctrl_reg[1:0];
         e.render = mask_reg[4:1];
         e.sx = scroll_x;
         e.sy = scroll_y;
         e.dma_page = dma_page;
         e.vblank = vblank;
         pending_rsp.push_back(e);
      endfunction

      task report(string what, logic [15:0] got_v, logic [15:0] want_v);
         if (errors < 40) $display("mismatch on %s: got %h, expected %h", what, got_v, want_v);
         errors++;
      endtask

      task check_rsp(bus_rsp_t got);
         bus_rsp_t want;
         if (pending_rsp.size() == 0) begin
            report("unexpected result", got.rdata, 0);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.rdata !== want.rdata) report("read_data", got.rdata, want.rdata);
         if (got.nmi !== want.nmi) report("nmi_enable", got.nmi, want.nmi);
         if (got.pattern !== want.pattern) report("pattern_select", got.pattern, want.pattern);
         if (got.nametable !== want.nametable)
            report("nametable_select", got.nametable, want.nametable);
         if (got.render !== want.render) report("render_controls", got.render, want.render);
         if (got.sx !== want.sx) report("scroll_x", got.sx, want.sx);
         if (got.sy !== want.sy) report("scroll_y", got.sy, want.sy);
         if (got.dma_req !== want.dma_req) report("dma_request", got.dma_req, want.dma_req);
         if (got.dma_page !== want.dma_page) report("dma_page", got.dma_page, want.dma_page);
         if (got.vblank !== want.vblank) report("vblank_flag", got.vblank, want.vblank);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [15:0] req_bus_addr = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_pad_buttons = '0;
   logic        req_sprite_hit = 1'b0;
   logic        req_sprite_overflow = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_read_data;
   logic        rsp_nmi_enable;
   logic [1:0]  rsp_pattern_select;
   logic [1:0]  rsp_nametable_select;
   logic [3:0]  rsp_render_controls;
   logic [7:0]  rsp_scroll_x;
   logic [7:0]  rsp_scroll_y;
   logic        rsp_dma_request;
   logic [7:0]  rsp_dma_page;
   logic        rsp_vblank_flag;

   regmap_scoreboard sb;
   int          n_sent = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;
   int          cycle_count = 0;
   logic [15:0] video_marks[$];
   logic [15:0] work_marks[$];

   console_cpu_bus_register_map_core u_top (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
      return $urandom_range(0, 16);
   endfunction

   function automatic bit read_safe(logic [15:0] a);
      if (a == ADDR_VDATA) return sb.cell_written(sb.mirror(sb.vaddr));
      if (a < WORK_RAM_LIMIT) return sb.work_ok[a[WORK_INDEX_W-1:0]];
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_video_base();
      case ($urandom_range(0, 6))
         0: return 16'($urandom_range(0, 63));
         1: return 16'h1FE0 + 16'($urandom_range(0, 31));
         2: return 16'h2000 + 16'($urandom_range(0, 63));
         3: return 16'h3EF0 + 16'($urandom_range(0, 15));
         4: return PALETTE_BASE + 16'($urandom_range(0, 31));
         5: return 16'hFFE0 + 16'($urandom_range(0, 31));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic drive(input logic [1:0] func, input logic [15:0] addr,
                        input logic [7:0] data);
      bus_req_t r;
      int       gap;
      r.func = func;
      r.addr = addr;
      r.wdata = data;
      r.buttons = 8'($urandom_range(0, 255));
      r.hit = 1'($urandom_range(0, 1));
      r.ovf = 1'($urandom_range(0, 1));
      gap = draw_idle(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= r.func;
      req_bus_addr <= r.addr;
      req_write_data <= r.wdata;
      req_pad_buttons <= r.buttons;
      req_sprite_hit <= r.hit;
      req_sprite_overflow <= r.ovf;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_access(r);
      n_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_vaddr(input logic [15:0] a);
      if (sb.addr_toggle) drive(FUNC_READ, ADDR_STATUS, 8'h00);
      drive(FUNC_WRITE, ADDR_VADDR, a[15:8]);
      drive(FUNC_WRITE, ADDR_VADDR, a[7:0]);
   endtask

   task automatic video_write_seq();
      logic [15:0] base;
      base = pick_video_base();
      if ($urandom_range(0, 2) == 0) drive(FUNC_WRITE, ADDR_CTRL, 8'($urandom_range(0, 255)));
      set_vaddr(base);
      video_marks.push_back(base);
      if (video_marks.size() > 24) void'(video_marks.pop_front());
      repeat ($urandom_range(1, 6)) drive(FUNC_WRITE, ADDR_VDATA, 8'($urandom_range(0, 255)));
   endtask

   task automatic video_read_seq();
      if (video_marks.size() == 0) begin
         video_write_seq();
         return;
      end
      if ($urandom_range(0, 5) == 0) drive(FUNC_WRITE, ADDR_CTRL, 8'($urandom_range(0, 255)));
      set_vaddr(video_marks[$urandom_range(0, video_marks.size() - 1)]);
      repeat ($urandom_range(1, 7)) begin
         if (read_safe(ADDR_VDATA)) drive(FUNC_READ, ADDR_VDATA, 8'($urandom_range(0, 255)));
         else drive(FUNC_WRITE, ADDR_VDATA, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic pad_seq();
      drive(FUNC_WRITE, ADDR_PAD, {7'($urandom_range(0, 127)), 1'($urandom_range(0, 5) != 0)});
      drive(FUNC_WRITE, ADDR_PAD, {7'($urandom_range(0, 127)), 1'($urandom_range(0, 5) == 0)});
      repeat ($urandom_range(1, 10)) drive(FUNC_READ, ADDR_PAD, 8'($urandom_range(0, 255)));
   endtask

   task automatic work_seq();
      logic [15:0] a;
      if (work_marks.size() == 0 || $urandom_range(0, 1) == 0) begin
         a = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'h07FF))
                                         : 16'($urandom_range(0, 31));
         drive(FUNC_WRITE, a, 8'($urandom_range(0, 255)));
         work_marks.push_back(a);
         if (work_marks.size() > 48) void'(work_marks.pop_front());
      end else begin
         repeat ($urandom_range(1, 3))
            drive(FUNC_READ, work_marks[$urandom_range(0, work_marks.size() - 1)],
                  8'($urandom_range(0, 255)));
      end
   endtask

   task automatic register_seq();
      case ($urandom_range(0, 7))
         0: drive(FUNC_WRITE, ADDR_CTRL, 8'($urandom_range(0, 255)));
         1: drive(FUNC_WRITE, ADDR_MASK, 8'($urandom_range(0, 255)));
         2: repeat (2) drive(FUNC_WRITE, ADDR_SCROLL, 8'($urandom_range(0, 255)));
         3: drive(FUNC_WRITE, ADDR_DMA, 8'($urandom_range(0, 255)));
         4: begin
            drive(FUNC_WRITE, ADDR_SPR_ADDR, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 3))
               drive(FUNC_WRITE, ADDR_SPR_DATA, 8'($urandom_range(0, 255)));
         end
         5: drive(FUNC_READ, ADDR_STATUS, 8'($urandom_range(0, 255)));
         6: drive(FUNC_VBLANK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
         default: begin
            drive(FUNC_VBLANK, ADDR_STATUS, 8'h00);
            drive(FUNC_READ, ADDR_STATUS, 8'h00);
         end
      endcase
   endtask

   task automatic noise_item();
      logic [1:0]  f;
      logic [15:0] a;
      f = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: a = 16'($urandom_range(0, 65535));
         1: a = 16'h2000 + 16'($urandom_range(0, 15));
         2: a = 16'h4000 + 16'($urandom_range(0, 31));
         default: a = 16'($urandom_range(0, 16'h0FFF));
      endcase
      if (f == FUNC_READ && !read_safe(a)) f = FUNC_WRITE;
      drive(f, a, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      bus_rsp_t got;
      int       stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_read_data, rsp_nmi_enable, rsp_pattern_select, rsp_nametable_select,
                   rsp_render_controls, rsp_scroll_x, rsp_scroll_y, rsp_dma_request,
                   rsp_dma_page, rsp_vblank_flag};
            sb.check_rsp(got);
            stall = draw_idle(rsp_calm);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      int next_drain;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      drive(FUNC_VBLANK, 16'h0000, 8'h00);
      drive(FUNC_READ, ADDR_STATUS, 8'h00);
      drive(FUNC_IDLE, 16'hFFFF, 8'hFF);
      drive(FUNC_WRITE, ADDR_CTRL, 8'hFF);
      drive(FUNC_WRITE, ADDR_MASK, 8'hFF);
      drive(FUNC_WRITE, ADDR_SCROLL, 8'hFF);
      drive(FUNC_WRITE, ADDR_SCROLL, 8'h00);
      // palette mirror, then step of 32
      set_vaddr(PAL_MIRROR_3);
      drive(FUNC_WRITE, ADDR_VDATA, 8'hA5);
      drive(FUNC_WRITE, ADDR_CTRL, 8'h00);
      set_vaddr(PAL_MIRROR_3 & PAL_MIRROR_MASK);
      drive(FUNC_READ, ADDR_VDATA, 8'h00);
      // buffered read just below the palette, bypass at its base
      set_vaddr(PALETTE_BASE - 16'd1);
      drive(FUNC_WRITE, ADDR_VDATA, 8'h5A);
      drive(FUNC_WRITE, ADDR_VDATA, 8'h3C);
      set_vaddr(PALETTE_BASE - 16'd1);
      drive(FUNC_READ, ADDR_VDATA, 8'h00);
      drive(FUNC_READ, ADDR_VDATA, 8'h00);
      drive(FUNC_WRITE, ADDR_DMA, 8'hFF);
      drive(FUNC_WRITE, WORK_RAM_LIMIT - 16'd1, 8'h00);
      drive(FUNC_READ, WORK_RAM_LIMIT - 16'd1, 8'h00);
      drive(FUNC_WRITE, WORK_RAM_LIMIT, 8'hFF);
      drive(FUNC_WRITE, ADDR_PAD, 8'h01);
      drive(FUNC_WRITE, ADDR_PAD, 8'h00);
      drive(FUNC_READ, ADDR_PAD, 8'h00);

      wait_drain();
      next_drain = n_sent + 350;
      while (n_sent < ITEM_TARGET) begin
         if (n_sent >= next_drain) begin
            wait_drain();
            next_drain = n_sent + 350;
         end
         case ($urandom_range(0, 15))
            0, 1, 2:       video_write_seq();
            3, 4, 5, 6:    video_read_seq();
            7, 8:          pad_seq();
            9, 10:         work_seq();
            11, 12, 15:    register_seq();
            default:       noise_item();
         endcase
      end

      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ccbrm_pkg.sv
hw/rtl/ccbrm_ram.sv
hw/rtl/ccbrm_decode.sv
hw/rtl/console_cpu_bus_register_map.sv
hw/rtl/ccbrm_checker.sv
test/console_cpu_bus_register_map_core_tb.sv
